// File: rtl/pwpr_pkg.sv
// Shared types and constants of the pulse-width packet receiver.
package pwpr_pkg;

  localparam int WIDTH_W       = 16;  // interval and width thresholds
  localparam int PRE_W         = 8;   // preamble threshold and bit counter
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 5;   // ring slot as seen on the result channel
  localparam int BITS_PER_BYTE = 8;
  localparam int Q_DEPTH       = 4;   // power of two

  localparam logic [WIDTH_W-1:0] ONE_MIN_RST  = 16'h00C0;
  localparam logic [WIDTH_W-1:0] ONE_MAX_RST  = 16'h0100;
  localparam logic [WIDTH_W-1:0] ZERO_MIN_RST = 16'h0080;
  localparam logic [PRE_W-1:0]   PRE_MIN_RST  = 8'd11;

  typedef enum logic [1:0] {
    CFG_ONE_MIN  = 2'd0,
    CFG_ONE_MAX  = 2'd1,
    CFG_ZERO_MIN = 2'd2,
    CFG_PRE_MIN  = 2'd3
  } cfg_idx_t;

  // Classified item: timeout tick, or edge with its window compares.
  typedef struct packed {
    logic tick;
    logic in_window;
    logic above_zero;
  } cls_t;

  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_push_t;

endpackage

// File: rtl/pwpr_in_if.sv
// Input channel: edge interval or timer tick.
interface pwpr_in_if;
  import pwpr_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [WIDTH_W-1:0] interval;

  modport source (output valid, output mode, output interval, input ready);
  modport sink   (input valid, input mode, input interval, output ready);
endinterface

// File: rtl/pwpr_out_if.sv
// Result channel: decoded byte with ring slot and packet end flag.
interface pwpr_out_if;
  import pwpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic [IDX_W-1:0]  byte_index;
  logic              packet_end;

  modport source (output valid, output byte_value, output byte_index, output packet_end,
                  input ready);
  modport sink   (input valid, input byte_value, input byte_index, input packet_end,
                  output ready);
endinterface

// File: rtl/pwpr_front.sv
// Front end: accepts items and classifies intervals against the width windows.
module pwpr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  pwpr_in_if.sink                    in_ch,
  input  logic                       cfg_we,
  input  pwpr_pkg::cfg_idx_t         cfg_index,
  input  logic [pwpr_pkg::WIDTH_W-1:0] cfg_data,
  output pwpr_pkg::cls_push_t        push,
  input  logic                       push_ready
);
  import pwpr_pkg::*;

  logic [WIDTH_W-1:0] one_min_r, one_max_r, zero_min_r;
  logic               fv_r, fv_nxt;
  cls_t               cls_r, cls_nxt;
  logic               take;

  assign in_ch.ready = !fv_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    cls_nxt.tick       = in_ch.mode;
    cls_nxt.in_window  = (in_ch.interval >= one_min_r) && (in_ch.interval <= one_max_r);
    cls_nxt.above_zero = in_ch.interval > zero_min_r;
  end

  always_comb begin
    if (take) begin
      fv_nxt = 1'b1;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end else begin
      fv_nxt = fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r       <= 1'b0;
      one_min_r  <= ONE_MIN_RST;
      one_max_r  <= ONE_MAX_RST;
      zero_min_r <= ZERO_MIN_RST;
    end else begin
      fv_r <= fv_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ONE_MIN:  one_min_r  <= cfg_data;
          CFG_ONE_MAX:  one_max_r  <= cfg_data;
          CFG_ZERO_MIN: zero_min_r <= cfg_data;
          CFG_PRE_MIN:  ;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
    end
  end

  assign push.valid = fv_r;
  assign push.cls   = cls_r;

endmodule

// File: rtl/pwpr_queue.sv
// Short queue of classified items between front and back end.
module pwpr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  pwpr_pkg::cls_push_t push,
  output logic                push_ready,
  output logic                pop_valid,
  output pwpr_pkg::cls_t      pop_cls,
  input  logic                pop
);
  import pwpr_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cls_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cls    = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cls;
    end
  end

endmodule

// File: rtl/pwpr_back.sv
// Back end: preamble search, byte assembly, separator handling, result register.
module pwpr_back #(
  parameter int RING_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  input  pwpr_pkg::cls_t             pop_cls,
  output logic                       pop,
  input  logic                       cfg_we,
  input  pwpr_pkg::cfg_idx_t         cfg_index,
  input  logic [pwpr_pkg::WIDTH_W-1:0] cfg_data,
  pwpr_out_if.source                 out_ch
);
  import pwpr_pkg::*;

  localparam int                SLOT_W = $clog2(RING_DEPTH);
  localparam logic [SLOT_W-1:0] LAST   = SLOT_W'(RING_DEPTH - 1);

  logic [PRE_W-1:0]  pre_min_r;
  logic              rx_r, rx_nxt;
  logic              to_r, to_nxt;
  logic [PRE_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sb_r, sb_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] obyte_r;
  logic [IDX_W-1:0]  oidx_r;
  logic              oend_r;

  logic              is_one, is_zero, emit;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign pop      = pop_valid && (!ov_r || out_ch.ready);
  assign is_one   = pop_cls.in_window && !to_r;
  assign is_zero  = pop_cls.above_zero || to_r;
  assign slot_ext = {{IDX_W{1'b0}}, slot_r};

  always_comb begin
    rx_nxt   = rx_r;
    to_nxt   = to_r;
    cnt_nxt  = cnt_r;
    sb_nxt   = sb_r;
    slot_nxt = slot_r;
    emit     = 1'b0;
    if (pop) begin
      priority if (pop_cls.tick) begin
        to_nxt = 1'b1;
      end else if (!rx_r) begin
        // preamble search
        if (is_one) begin
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (is_zero && (cnt_r > pre_min_r)) begin
          rx_nxt  = 1'b1;
          to_nxt  = 1'b0;
          cnt_nxt = '0;
          sb_nxt  = '0;
        end
      end else if (cnt_r < PRE_W'(BITS_PER_BYTE)) begin
        // data bit; an undecided interval still counts but leaves the byte
        if (is_one) begin
          sb_nxt = {sb_r[BYTE_W-2:0], 1'b1};
        end else if (is_zero) begin
          sb_nxt = {sb_r[BYTE_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        // separator
        emit    = 1'b1;
        cnt_nxt = '0;
        if (is_one) begin
          rx_nxt = 1'b0;
        end else begin
          slot_nxt = (slot_r == LAST) ? '0 : slot_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_min_r <= PRE_MIN_RST;
      rx_r      <= 1'b0;
      to_r      <= 1'b0;
      cnt_r     <= '0;
      sb_r      <= '0;
      slot_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      rx_r   <= rx_nxt;
      to_r   <= to_nxt;
      cnt_r  <= cnt_nxt;
      sb_r   <= sb_nxt;
      slot_r <= slot_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we && (cfg_index == CFG_PRE_MIN)) begin
        pre_min_r <= cfg_data[PRE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r <= sb_r;
      oidx_r  <= slot_ext[IDX_W-1:0];
      oend_r  <= is_one;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.byte_value = obyte_r;
  assign out_ch.byte_index = oidx_r;
  assign out_ch.packet_end = oend_r;

endmodule

// File: rtl/pulse_width_packet_receiver_top.sv
// Pulse-width packet receiver: one item per cycle sustained; the front stage,
// the four-entry queue and the result register let either side stall alone.
// The separator item passes through the front stage, a queue slot and the result register,
// in that order, before out_ch.valid rises.
// Reset (rst_n low, synchronous): thresholds return to defaults, decoder to
// preamble search, queue and result register empty.
module pulse_width_packet_receiver_top #(
  parameter int RING_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pwpr_in_if.sink                      in_ch,
  pwpr_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  pwpr_pkg::cfg_idx_t           cfg_index,
  input  logic [pwpr_pkg::WIDTH_W-1:0] cfg_data
);
  import pwpr_pkg::*;

  cls_push_t push;
  logic      push_ready;
  logic      pop_valid;
  cls_t      pop_cls;
  logic      pop;

  pwpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_ready (push_ready)
  );

  pwpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cls    (pop_cls),
    .pop        (pop)
  );

  pwpr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cls   (pop_cls),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/tb_pulse_width_packet_receiver_top.sv
// Self-checking testbench for the pulse-width packet receiver: directed and random line traffic, checked per byte.
module tb_pulse_width_packet_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pwpr_pkg::*;

  localparam logic MODE_EDGE     = 1'b0;
  localparam logic MODE_TICK     = 1'b1;
  localparam int   RING_SLOTS    = 32;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   CYCLE_LIMIT   = 200000;
  localparam int   MAX_LINES     = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [IDX_W-1:0]  slot;
    logic              ends_packet;
  } byte_rec_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [WIDTH_W-1:0] cfg_data;

  pwpr_in_if  in_ch ();
  pwpr_out_if out_ch ();

  pulse_width_packet_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Decoder state as the testbench tracks it.
  logic [WIDTH_W-1:0] thr_one_min, thr_one_max, thr_zero_min;
  logic [PRE_W-1:0]   thr_pre_min;
  logic               rx_active;
  logic               timeout_seen;
  logic [PRE_W-1:0]   bit_cnt;
  logic [BYTE_W-1:0]  shift_reg;
  int                 ring_slot;

  byte_rec_t pending_bytes[$];

  int   cycles;
  int   errors;
  int   items_sent;
  int   bytes_checked;
  int   ends_checked;
  int   cfg_writes;
  bit   idle_en;
  logic holding;
  event hold_go;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic reset_decoder_model();
    thr_one_min  = ONE_MIN_RST;
    thr_one_max  = ONE_MAX_RST;
    thr_zero_min = ZERO_MIN_RST;
    thr_pre_min  = PRE_MIN_RST;
    rx_active    = 1'b0;
    timeout_seen = 1'b0;
    bit_cnt      = '0;
    shift_reg    = '0;
    ring_slot    = 0;
  endtask

  // Advance the decoder by one item; return 1 when it completes a byte.
  function automatic bit decode_pulse(input logic mode, input logic [WIDTH_W-1:0] iv,
                                      output byte_rec_t rec);
    logic is_one, is_zero;
    rec = '0;
    if (mode == MODE_TICK) begin
      timeout_seen = 1'b1;
      return 1'b0;
    end
    is_one  = iv >= thr_one_min && iv <= thr_one_max && !timeout_seen;
    is_zero = iv > thr_zero_min || timeout_seen;
    if (!rx_active) begin
      if (is_one) begin
        if (bit_cnt != 8'd255) bit_cnt++;
      end else if (is_zero && bit_cnt > thr_pre_min) begin
        rx_active    = 1'b1;
        timeout_seen = 1'b0;
        bit_cnt      = '0;
        shift_reg    = '0;
      end
      return 1'b0;
    end
    if (bit_cnt < PRE_W'(BITS_PER_BYTE)) begin
      if (is_one) shift_reg = {shift_reg[BYTE_W-2:0], 1'b1};
      else if (is_zero) shift_reg = {shift_reg[BYTE_W-2:0], 1'b0};
      bit_cnt++;
      return 1'b0;
    end
    // separator bit
    rec.value       = shift_reg;
    rec.slot        = ring_slot[IDX_W-1:0];
    rec.ends_packet = is_one;
    if (is_one) rx_active = 1'b0;
    else ring_slot = (ring_slot + 1) % RING_SLOTS;
    bit_cnt = '0;
    return 1'b1;
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_one();
    return WIDTH_W'($urandom_range(int'(thr_one_max), int'(thr_one_min)));
  endfunction

  // Interval above the zero threshold and outside the one window, where one exists.
  function automatic logic [WIDTH_W-1:0] pick_zero();
    int lo, r, omin, omax;
    omin = int'(thr_one_min);
    omax = int'(thr_one_max);
    lo   = int'(thr_zero_min) + 1;
    if (lo > 65535) return 16'hFFFF;
    r = $urandom_range(65535, lo);
    if (r < omin || r > omax) return WIDTH_W'(r);
    if (omax < 65535) return WIDTH_W'($urandom_range(65535, omax + 1));
    if (omin > lo) return WIDTH_W'($urandom_range(omin - 1, lo));
    return WIDTH_W'(r);
  endfunction

  // Interval that is neither a one nor a zero, where one exists.
  function automatic logic [WIDTH_W-1:0] pick_neither();
    int r, omin, omax, zmin;
    omin = int'(thr_one_min);
    omax = int'(thr_one_max);
    zmin = int'(thr_zero_min);
    r = $urandom_range(zmin, 0);
    if (r < omin || r > omax) return WIDTH_W'(r);
    if (omin > 0) return WIDTH_W'($urandom_range(omin - 1, 0));
    if (omax < zmin) return WIDTH_W'($urandom_range(zmin, omax + 1));
    return WIDTH_W'(r);
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_data_interval();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return pick_neither();
    if (r < 55) return pick_one();
    return pick_zero();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_LINES)
      $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
  endtask

  // Offer one item and hold it until accepted, then predict its outcome.
  task automatic send_item(input logic mode, input logic [WIDTH_W-1:0] iv);
    byte_rec_t rec;
    if (idle_en && $urandom_range(99, 0) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.interval <= iv;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_pulse(mode, iv, rec)) pending_bytes.push_back(rec);
    items_sent++;
  endtask

  task automatic send_edge(input logic [WIDTH_W-1:0] iv);
    send_item(MODE_EDGE, iv);
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WIDTH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_ONE_MIN:  thr_one_min  = value;
      CFG_ONE_MAX:  thr_one_max  = value;
      CFG_ZERO_MIN: thr_zero_min = value;
      CFG_PRE_MIN:  thr_pre_min  = value[PRE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_thresholds(input logic [WIDTH_W-1:0] omin, input logic [WIDTH_W-1:0] omax,
                                  input logic [WIDTH_W-1:0] zmin, input logic [PRE_W-1:0] pmin);
    drain();
    write_reg(CFG_ONE_MIN, omin);
    write_reg(CFG_ONE_MAX, omax);
    write_reg(CFG_ZERO_MIN, zmin);
    // upper byte is don't-care for the preamble register
    write_reg(CFG_PRE_MIN, {8'($urandom), pmin});
    cfg_we <= 1'b0;
  endtask

  // Close any open packet with ones so the decoder is back in preamble search.
  task automatic return_to_search();
    int guard;
    guard = 0;
    while (rx_active && guard < 12) begin
      send_edge(pick_one());
      guard++;
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) begin
      if (!rx_active && bit_cnt > thr_pre_min && $urandom_range(7, 0) == 0) begin
        send_item(MODE_TICK, 16'($urandom));
        // any edge now reads as zero and starts reception, clearing the timeout
        send_edge(16'($urandom));
      end else begin
        send_edge(16'($urandom));
      end
    end
  endtask

  task automatic send_packet(input int nbytes);
    int guard;
    return_to_search();
    if (rx_active || thr_pre_min == 8'd255) return;
    repeat ($urandom_range(3, 0)) send_edge(pick_one());
    guard = 0;
    while (bit_cnt <= thr_pre_min && guard < 300) begin
      send_edge(pick_one());
      guard++;
    end
    if ($urandom_range(9, 0) == 0) send_item(MODE_TICK, 16'($urandom));
    send_edge(pick_zero());
    for (int b = 0; b < nbytes; b++) begin
      for (int k = 0; k < BITS_PER_BYTE; k++) begin
        if ($urandom_range(39, 0) == 0) return;  // broken packet
        send_edge(pick_data_interval());
      end
      if (b == nbytes - 1) send_edge(pick_one());
      else send_edge($urandom_range(9, 0) == 0 ? pick_neither() : pick_zero());
    end
  endtask

  task automatic run_traffic(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(4, 0) == 0) send_noise($urandom_range(5, 1));
      else send_packet($urandom_range(4, 1));
    end
  endtask

  task automatic test_directed();
    apply_thresholds(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, 8'd0);
    send_edge(16'd0);        // neither, ignored in preamble search
    send_edge(16'd100);      // neither
    send_edge(16'hFFFF);     // zero after a too-short preamble, count kept
    send_edge(16'd192);      // one at the window floor
    send_item(MODE_TICK, 16'hFFFF);
    send_edge(16'd200);      // in window but timed out: zero, starts reception
    send_edge(16'd256);
    send_edge(16'd129);
    send_edge(16'd128);      // neither: counts, no shift
    send_edge(16'd192);
    send_edge(16'd0);
    send_edge(16'hFFFF);
    send_edge(16'd200);
    send_edge(16'd300);
    send_edge(16'd50);       // neither as separator: stored, packet goes on
    repeat (BITS_PER_BYTE) send_edge(16'd256);
    send_edge(16'd224);      // one as separator: packet end
  endtask

  task automatic test_default_traffic();
    apply_thresholds(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, PRE_MIN_RST);
    run_traffic(300);
  endtask

  task automatic test_threshold_sweep();
    apply_thresholds(16'd1, 16'd1, 16'd0, 8'd0);
    run_traffic(200);
    apply_thresholds(16'd0, 16'd65534, 16'd65534, 8'd3);
    run_traffic(150);
    apply_thresholds(16'd40000, 16'hFFFF, 16'd100, 8'd20);
    run_traffic(200);
  endtask

  task automatic test_empty_window();
    apply_thresholds(16'hFFFF, 16'd0, 16'd0, 8'd255);
    send_noise(40);
  endtask

  task automatic test_preamble_saturation();
    apply_thresholds(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, 8'd254);
    return_to_search();
    repeat (260) send_edge(pick_one());
    send_edge(pick_zero());
    repeat (BITS_PER_BYTE) send_edge(pick_data_interval());
    send_edge(pick_one());
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    run_traffic(150);
    idle_en = 1'b1;
  endtask

  task automatic test_output_hold();
    apply_thresholds(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, 8'd0);
    -> hold_go;
    run_traffic(150);
  endtask

  // A tick while receiving blocks every one bit for good: run it last.
  task automatic test_timeout_lock();
    apply_thresholds(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, 8'd0);
    return_to_search();
    send_edge(pick_one());
    send_edge(pick_zero());
    send_item(MODE_TICK, 16'd0);
    repeat (2 * (BITS_PER_BYTE + 1)) send_edge(16'($urandom));
  endtask

  // Result ready: random idling, plus a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holding) out_ch.ready <= 1'b0;
      else if (idle_en && $urandom_range(99, 0) < 6) out_ch.ready <= 1'b0;
      else out_ch.ready <= 1'b1;
    end
  end

  initial begin
    holding <= 1'b0;
    forever begin
      @(hold_go);
      @(posedge clk);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    byte_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", int'(out_ch.byte_value), 0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.byte_value !== want.value)
          report_mismatch("byte_value", int'(out_ch.byte_value), int'(want.value));
        if (out_ch.byte_index !== want.slot)
          report_mismatch("byte_index", int'(out_ch.byte_index), int'(want.slot));
        if (out_ch.packet_end !== want.ends_packet)
          report_mismatch("packet_end", int'(out_ch.packet_end), int'(want.ends_packet));
        bytes_checked++;
        if (want.ends_packet) ends_checked++;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d bytes still expected", cycles, pending_bytes.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    errors         = 0;
    items_sent     = 0;
    bytes_checked  = 0;
    ends_checked   = 0;
    cfg_writes     = 0;
    idle_en        = 1'b1;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_EDGE;
    in_ch.interval <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_ONE_MIN;
    cfg_data       <= '0;
    reset_decoder_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_default_traffic();
    test_threshold_sweep();
    test_empty_window();
    test_preamble_saturation();
    test_no_idle();
    test_output_hold();
    test_timeout_lock();
    drain();

    $display("Sent %0d items over %0d register writes; checked %0d bytes, %0d packet ends",
             items_sent, cfg_writes, bytes_checked, ends_checked);
    $display("Covered window extremes, empty window, preamble saturation, hold-off, timeout lock");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
